@@ sv/uo_pkg.sv @@
// Package for the ultimate oscillator: shared types, state codes, register
// indexes and command/status structs between controller and datapath. No dependencies.
package uo_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_DIV,
    ST_MIX,
    ST_DONE
  } state_t;

  localparam logic [1:0] STATUS_VALID = 2'd0;
  localparam logic [1:0] STATUS_WARMUP = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_LONG = 2'd2;

  localparam int CfgBits = 7;
  localparam int QuoBits = 16;

  typedef struct packed {
    logic load;       // register the accepted bar
    logic write;      // write ring slot, advance head
    logic sum_clear;  // start of the summing sweep
    logic sum_step;   // add one ring entry into the window sums
    logic div_start;  // start one ratio division
    logic div_step;   // one quotient bit
    logic mix;        // form the weighted result
  } cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_bit_done;
    logic div_all_done;
  } stat_t;

endpackage

@@ sv/uo_ctrl.sv @@
// Controller for the ultimate oscillator: sequences write, summing sweep,
// three shared divisions and output. Depends on uo_pkg.
module uo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_busy,
  input  uo_pkg::stat_t   stat,
  output uo_pkg::cmd_t    cmd,
  output logic            in_ready,
  output logic            out_load
);

  uo_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= uo_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      uo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = uo_pkg::ST_WRITE;
        end
      end
      uo_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        cmd.sum_clear = 1'b1;
        state_next = uo_pkg::ST_SUM;
      end
      uo_pkg::ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_done) begin
          cmd.div_start = 1'b1;
          state_next = uo_pkg::ST_DIV;
        end
      end
      uo_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_bit_done) begin
          if (stat.div_all_done) state_next = uo_pkg::ST_MIX;
          else cmd.div_start = 1'b1;
        end
      end
      uo_pkg::ST_MIX: begin
        cmd.mix = 1'b1;
        state_next = uo_pkg::ST_DONE;
      end
      uo_pkg::ST_DONE: begin
        if (!out_busy) begin
          out_load = 1'b1;
          state_next = uo_pkg::ST_IDLE;
        end
      end
      default: state_next = uo_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ sv/uo_dp.sv @@
// Datapath for the ultimate oscillator: bar registers, rings, window sums,
// shared restoring divider and weighted mix. Depends on uo_pkg.
module uo_dp #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  uo_pkg::cmd_t                cmd,
  output uo_pkg::stat_t               stat,
  input  logic [31:0]                 high_price,
  input  logic [31:0]                 low_price,
  input  logic [31:0]                 close_price,
  input  logic [uo_pkg::CfgBits-1:0]  short_window,
  input  logic [uo_pkg::CfgBits-1:0]  middle_window,
  input  logic [uo_pkg::CfgBits-1:0]  long_window,
  output logic [22:0]                 res_osc,
  output logic [1:0]                  res_status
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int VW = PRICE_BITS + 1;
  localparam int SW = VW + AW + 1;
  localparam int CLAMP_W = (uo_pkg::CfgBits > CW) ? uo_pkg::CfgBits : CW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_WINDOW);
  localparam logic [AW-1:0] LastSlot = AW'(MAX_WINDOW - 1);
  localparam logic [26:0] RecipSeven = 27'd76695845;

  logic [PRICE_BITS-1:0] hi, lo, cl, prev;
  logic [AW-1:0] head;
  logic [CW-1:0] seen;
  logic [CW-1:0] w0, w1, w2, need;

  logic signed [VW-1:0] pmem [MAX_WINDOW];
  logic [VW-1:0] rmem [MAX_WINDOW];
  logic signed [VW-1:0] prd;
  logic [VW-1:0] rrd;

  function automatic logic [CW-1:0] eff(input logic [uo_pkg::CfgBits-1:0] w);
    logic [CLAMP_W-1:0] x;
    x = CLAMP_W'(w);
    if (x == '0) return CW'(1);
    if (x > CLAMP_W'(MAX_WINDOW)) return MaxCnt;
    return CW'(x);
  endfunction

  assign w0 = eff(short_window);
  assign w1 = eff(middle_window);
  assign w2 = eff(long_window);
  always_comb begin
    need = w0;
    if (w1 > need) need = w1;
    if (w2 > need) need = w2;
  end

  // Pressure and true range of the registered bar.
  logic [PRICE_BITS-1:0] pc, tlo;
  logic [PRICE_BITS-1:0] d_hl, d_hp, d_lp, rng;
  logic signed [VW-1:0] press;
  assign pc = (seen == '0) ? cl : prev;
  assign tlo = (lo < pc) ? lo : pc;
  assign press = $signed({1'b0, cl}) - $signed({1'b0, tlo});
  assign d_hl = (hi >= lo) ? hi - lo : '0;
  assign d_hp = (hi >= pc) ? hi - pc : pc - hi;
  assign d_lp = (lo >= pc) ? lo - pc : pc - lo;
  always_comb begin
    rng = d_hl;
    if (d_hp > rng) rng = d_hp;
    if (d_lp > rng) rng = d_lp;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi <= PRICE_BITS'(high_price);
      lo <= PRICE_BITS'(low_price);
      cl <= PRICE_BITS'(close_price);
    end
  end

  // Summing sweep: k counts back from the newest entry while raddr walks the
  // ring backward; one read per cycle, data arrives in the cycle after (kd).
  logic [CW-1:0] k, kd, nlim;
  logic rd_v;
  logic signed [SW-1:0] ps [3];
  logic [SW-1:0] rs [3];
  logic [AW-1:0] raddr;

  assign nlim = (seen < need) ? seen : need;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      pmem[head] <= press;
      rmem[head] <= {1'b0, rng};
    end
    prd <= pmem[raddr];
    rrd <= rmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      seen <= '0;
      prev <= '0;
      k <= '0;
      rd_v <= 1'b0;
      kd <= '0;
      raddr <= '0;
    end else begin
      if (cmd.write) begin
        head <= (head == LastSlot) ? '0 : head + AW'(1);
        if (seen < MaxCnt) seen <= seen + CW'(1);
        prev <= cl;
        k <= '0;
        rd_v <= 1'b0;
        raddr <= head;
      end else if (cmd.sum_step) begin
        rd_v <= (k < nlim);
        kd <= k;
        if (k < nlim) begin
          k <= k + CW'(1);
          raddr <= (raddr == '0) ? LastSlot : raddr - AW'(1);
        end
      end
    end
  end

  assign stat.sum_done = (k >= nlim) && !rd_v;

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      for (int j = 0; j < 3; j++) begin
        ps[j] <= '0;
        rs[j] <= '0;
      end
    end else if (cmd.sum_step && rd_v) begin
      if (kd < w0) begin
        ps[0] <= ps[0] + SW'(prd);
        rs[0] <= rs[0] + SW'(rrd);
      end
      if (kd < w1) begin
        ps[1] <= ps[1] + SW'(prd);
        rs[1] <= rs[1] + SW'(rrd);
      end
      if (kd < w2) begin
        ps[2] <= ps[2] + SW'(prd);
        rs[2] <= rs[2] + SW'(rrd);
      end
    end
  end

  // Shared restoring divider, one quotient bit per cycle, three windows.
  logic [1:0] widx;
  logic [4:0] bitc;
  logic [SW:0] rem;
  logic [SW-1:0] dvs;
  logic [uo_pkg::QuoBits:0] quo;
  logic [uo_pkg::QuoBits:0] ratio [3];
  logic skip;
  logic signed [SW-1:0] psel;
  logic [SW-1:0] rsel;
  logic [SW:0] rem2;

  always_comb begin
    case (widx)
      2'd0: begin psel = ps[0]; rsel = rs[0]; end
      2'd1: begin psel = ps[1]; rsel = rs[1]; end
      default: begin psel = ps[2]; rsel = rs[2]; end
    endcase
  end

  assign rem2 = {rem[SW-1:0], 1'b0};
  assign stat.div_bit_done = skip || (bitc == 5'(uo_pkg::QuoBits));
  assign stat.div_all_done = (widx == 2'd2);

  // When one window finishes, its bit counter clears and the index advances;
  // the restart cycle that follows loads the next window's operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
      bitc <= '0;
      skip <= 1'b0;
    end else if (cmd.sum_clear) begin
      widx <= '0;
    end else if (cmd.div_start) begin
      bitc <= '0;
      skip <= 1'b0;
      rem <= '0;
      quo <= '0;
      dvs <= rsel;
      if (psel <= 0 || rsel == '0) begin
        skip <= 1'b1;
      end else if ($unsigned(psel) >= rsel) begin
        skip <= 1'b1;
        quo <= (uo_pkg::QuoBits+1)'(1) << uo_pkg::QuoBits;
      end else begin
        rem <= {1'b0, $unsigned(psel)};
      end
    end else if (cmd.div_step) begin
      if (stat.div_bit_done) begin
        bitc <= '0;
        skip <= 1'b0;
        if (!stat.div_all_done) widx <= widx + 2'd1;
      end else begin
        bitc <= bitc + 5'd1;
        if (rem2 >= {1'b0, dvs}) begin
          rem <= rem2 - {1'b0, dvs};
          quo <= {quo[uo_pkg::QuoBits-1:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[uo_pkg::QuoBits-1:0], 1'b0};
        end
      end
    end
    if (cmd.div_step && stat.div_bit_done) ratio[widx] <= quo;
  end

  logic [19:0] wsum;
  logic [26:0] scaled;
  logic [53:0] prod7;
  logic [22:0] osc_q;
  assign wsum = {1'b0, ratio[0], 2'b0} + {2'b0, ratio[1], 1'b0} + {3'b0, ratio[2]};
  assign scaled = 27'(wsum) * 27'd100;
  // Divide by seven with a reciprocal multiply; exact over the whole range of scaled.
  assign prod7 = 54'(scaled) * 54'(RecipSeven);
  assign osc_q = prod7[51:29];

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      if (seen < need) begin
        res_osc <= '0;
        res_status <= uo_pkg::STATUS_WARMUP;
      end else if (rs[0] == '0 || rs[1] == '0 || rs[2] == '0) begin
        res_osc <= '0;
        res_status <= uo_pkg::STATUS_ZERO;
      end else begin
        res_osc <= osc_q;
        res_status <= uo_pkg::STATUS_VALID;
      end
    end
  end

endmodule

@@ sv/uo_ctrl_fix.sv @@
// Division sequencer helper: holds the restart request for one cycle so a
// new window's operands load after the index advances. Depends on uo_pkg.
module uo_ctrl_fix (
  input  logic          clk,
  input  logic          rst,
  input  uo_pkg::cmd_t  cmd_in,
  input  uo_pkg::stat_t stat,
  output uo_pkg::cmd_t  cmd_out
);

  logic restart;

  always_ff @(posedge clk) begin
    if (rst) restart <= 1'b0;
    else restart <= cmd_in.div_step && stat.div_bit_done && !stat.div_all_done;
  end

  always_comb begin
    cmd_out = cmd_in;
    if (restart) begin
      cmd_out.div_start = 1'b1;
      cmd_out.div_step = 1'b0;
    end else if (cmd_in.div_step && stat.div_bit_done) begin
      cmd_out.div_start = 1'b0;
    end
  end

endmodule

@@ sv/ultimate_oscillator.sv @@
// Ultimate oscillator over three windows of 1..MAX_WINDOW bars, one bar at a
// time. A request is registered when taken and written to the rings in the next.
// A sweep then reads one ring entry per cycle over min(bars seen, largest
// window) entries. One shared divider forms the three Q16 ratios at one
// quotient bit per cycle, skipping the bit steps when the ratio clamps or the
// range is zero, and loads the next window's operands in a restart step between
// windows. Mix and output follow; the next request is taken only after the
// result is loaded to the output, which waits while the output is stalled.
// Result: oscillator in Q16 percent and status (0 valid, 1 warming up, 2 zero
// range). Ring entries are never read before they are written, so there is no
// clearing pass after reset.
module ultimate_oscillator #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] high_price,
  input  logic [31:0] low_price,
  input  logic [31:0] close_price,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [22:0] oscillator,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [6:0] short_window, middle_window, long_window;
  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= 7'd7;
      middle_window <= 7'd14;
      long_window <= 7'd28;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uo_pkg::REG_SHORT: short_window <= cfg_data;
        uo_pkg::REG_MIDDLE: middle_window <= cfg_data;
        uo_pkg::REG_LONG: long_window <= cfg_data;
        default: ;
      endcase
    end
  end

  uo_pkg::cmd_t cmd_raw, cmd;
  uo_pkg::stat_t stat;
  logic in_ready, out_load, in_fire;
  logic [22:0] res_osc;
  logic [1:0] res_status;

  assign in_fire = in_valid && in_ready;
  assign in_stall = !in_ready;

  uo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && out_stall),
    .stat(stat), .cmd(cmd_raw), .in_ready(in_ready), .out_load(out_load)
  );

  uo_ctrl_fix u_fix (
    .clk(clk), .rst(rst), .cmd_in(cmd_raw), .stat(stat), .cmd_out(cmd)
  );

  uo_dp #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .high_price(high_price), .low_price(low_price), .close_price(close_price),
    .short_window(short_window), .middle_window(middle_window),
    .long_window(long_window), .res_osc(res_osc), .res_status(res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      oscillator <= res_osc;
      status <= res_status;
    end
  end

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != uo_pkg::STATUS_VALID |-> oscillator == '0)
    else $error("nonzero oscillator with nonvalid status");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_stall)
    else $error("accepted a bar while one is in flight");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_start && cmd.div_step))
    else $error("divider started and stepped together");

endmodule

@@ tb/sv/tb_ultimate_oscillator.sv @@
// Testbench for ultimate_oscillator: random and directed price bars through
// the valid/stall ports, predicted results checked in order. Depends on uo_pkg.
`timescale 1ns / 1ps

module tb_ultimate_oscillator;

  localparam int RING = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_OFF = 3000;
  localparam int HOLD_PHASE = 2;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] cl;
  } bar_t;

  typedef struct packed {
    logic [22:0] osc;
    logic [1:0]  stat;
  } osc_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] high_price = '0;
  logic [31:0] low_price = '0;
  logic [31:0] close_price = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [22:0] oscillator;
  logic [1:0]  status;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        in_taken = 1'b0;

  ultimate_oscillator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .high_price(high_price), .low_price(low_price), .close_price(close_price),
    .out_valid(out_valid), .out_stall(out_stall),
    .oscillator(oscillator), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bar_t        bar_queue[$];
  osc_result_t expected_results[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          phase_now = -1;
  int          hold_off_cycles = 0;
  bit          hold_off_done = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int          accepted_bars = 0;

  // Predictor state.
  logic [6:0]         win_reg[3];
  logic signed [32:0] pressure_hist[RING];
  logic [32:0]        range_hist[RING];
  int                 head = 0;
  int                 seen = 0;
  logic [31:0]        last_close = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int clamp_window(logic [6:0] w);
    if (w == 0) return 1;
    if (w > RING) return RING;
    return int'(w);
  endfunction

  function automatic logic [16:0] ratio_q16(logic signed [39:0] p, logic [39:0] r);
    logic [40:0] rem;
    logic [16:0] q;
    q = '0;
    if (p <= 0) return 17'd0;
    if ($unsigned(p) >= r) return 17'd65536;
    rem = {1'b0, p};
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= {1'b0, r}) begin
        rem = rem - {1'b0, r};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic osc_result_t predict_bar(bar_t b);
    osc_result_t res;
    logic [31:0]        pc;
    logic [31:0]        floor_low;
    logic [32:0]        rng;
    logic [32:0]        t;
    logic signed [39:0] psum[3];
    logic [39:0]        rsum[3];
    logic [16:0]        ratio[3];
    logic [31:0]        mix;
    int                 w[3];
    int                 need;
    int                 n;
    bit                 zero;
    pc = (seen == 0) ? b.cl : last_close;
    floor_low = (b.lo < pc) ? b.lo : pc;
    rng = (b.hi >= b.lo) ? {1'b0, b.hi - b.lo} : '0;
    t = (b.hi >= pc) ? {1'b0, b.hi - pc} : {1'b0, pc - b.hi};
    if (t > rng) rng = t;
    t = (b.lo >= pc) ? {1'b0, b.lo - pc} : {1'b0, pc - b.lo};
    if (t > rng) rng = t;
    pressure_hist[head] = $signed({1'b0, b.cl}) - $signed({1'b0, floor_low});
    range_hist[head] = rng;
    head = (head + 1) % RING;
    if (seen < RING) seen++;
    last_close = b.cl;
    need = 0;
    zero = 0;
    for (int j = 0; j < 3; j++) begin
      w[j] = clamp_window(win_reg[j]);
      if (w[j] > need) need = w[j];
      n = (w[j] < seen) ? w[j] : seen;
      psum[j] = '0;
      rsum[j] = '0;
      for (int k = 0; k < n; k++) begin
        psum[j] += pressure_hist[(head + RING - 1 - k) % RING];
        rsum[j] += range_hist[(head + RING - 1 - k) % RING];
      end
      if (rsum[j] == 0) zero = 1;
    end
    res.osc = '0;
    if (seen < need) begin
      res.stat = uo_pkg::STATUS_WARMUP;
    end else if (zero) begin
      res.stat = uo_pkg::STATUS_ZERO;
    end else begin
      for (int j = 0; j < 3; j++) ratio[j] = ratio_q16(psum[j], rsum[j]);
      mix = 32'd100 * (32'd4 * ratio[0] + 32'd2 * ratio[1] + ratio[2]) / 32'd7;
      res.osc = mix[22:0];
      res.stat = uo_pkg::STATUS_VALID;
    end
    return res;
  endfunction

  function automatic void queue_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c);
    bar_t b;
    b = {h, l, c};
    bar_queue.insert(bar_queue.size(), b);
  endfunction

  // Remembers whether the request on the port was taken at the last rising edge.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // Driver: a new request is presented at the falling edge once the last was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (bar_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        bar_t b;
        b = bar_queue.pop_front();
        high_price <= b.hi;
        low_price <= b.lo;
        close_price <= b.cl;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off counted here.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (phase_now == HOLD_PHASE && !hold_off_done) begin
      hold_off_done <= 1'b1;
      hold_off_cycles <= HOLD_OFF;
      out_stall <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result osc=%0d status=%0d", $time, oscillator, status);
          errors <= errors + 1;
        end else begin
          osc_result_t e;
          e = expected_results.pop_front();
          if (e.osc !== oscillator || e.stat !== status) begin
            $display("%0t: mismatch expected osc=%0d status=%0d actual osc=%0d status=%0d",
                     $time, e.osc, e.stat, oscillator, status);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                predict_bar({high_price, low_price, close_price}));
        accepted_bars <= accepted_bars + 1;
      end
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb_ultimate_oscillator failed");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (bar_queue.size() == 0);
    @(posedge clk);
    while (in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_window(logic [1:0] idx, logic [6:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_reg[idx] = value;
  endtask

  function automatic logic [31:0] rand_price(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'd1000 + $urandom_range(50);
      2: return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom_range(20);
    endcase
  endfunction

  // Mostly sensible bars around a drifting level; some fully random ones.
  task automatic queue_random_bars(int count);
    logic [31:0] base;
    logic [31:0] a;
    logic [31:0] b;
    base = 32'd100000;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        int m;
        m = $urandom_range(3);
        queue_bar(rand_price(m), rand_price(m), rand_price(m));
      end else if ($urandom_range(19) == 0) begin
        queue_bar(base, base, base);
      end else begin
        base = base + $urandom_range(200) - 100;
        a = base + $urandom_range(300);
        b = base - $urandom_range(300);
        queue_bar(a, b, b + $urandom_range(a - b + 40) - 20);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = uo_pkg::REG_SHORT;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    win_reg[0] = 7'd7;
    win_reg[1] = 7'd14;
    win_reg[2] = 7'd28;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Small windows first so directed cases leave warm-up quickly.
    write_window(uo_pkg::REG_SHORT, 7'd1);
    write_window(uo_pkg::REG_MIDDLE, 7'd2);
    write_window(uo_pkg::REG_LONG, 7'd3);
    queue_bar(32'd0, 32'd0, 32'd0);
    queue_bar(32'd0, 32'd0, 32'd0);
    queue_bar(32'd0, 32'd0, 32'd0);
    queue_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    queue_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    queue_bar(32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_bar(32'd10, 32'd20, 32'd30);
    queue_bar(32'd50, 32'd40, 32'd0);
    queue_bar(32'd50, 32'd40, 32'd100);
    queue_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_bar(32'd7, 32'd7, 32'd7);
    queue_bar(32'd7, 32'd7, 32'd7);
    queue_bar(32'd7, 32'd7, 32'd7);
    drain();

    // Out-of-range register values, zero and above the ring size.
    write_window(uo_pkg::REG_SHORT, 7'd0);
    write_window(uo_pkg::REG_MIDDLE, 7'd127);
    write_window(uo_pkg::REG_LONG, 7'd65);
    queue_random_bars(150);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (phase == 4) begin
        write_window(uo_pkg::REG_SHORT, 7'd64);
        write_window(uo_pkg::REG_MIDDLE, 7'd64);
        write_window(uo_pkg::REG_LONG, 7'd64);
      end else if (phase == 7) begin
        write_window(uo_pkg::REG_SHORT, 7'd7);
        write_window(uo_pkg::REG_MIDDLE, 7'd14);
        write_window(uo_pkg::REG_LONG, 7'd28);
      end else begin
        write_window(uo_pkg::REG_SHORT, 7'($urandom_range(1, 20)));
        write_window(uo_pkg::REG_MIDDLE, 7'($urandom_range(1, 40)));
        write_window(uo_pkg::REG_LONG, 7'($urandom_range(1, 64)));
      end
      phase_now = phase;
      queue_random_bars(180);
      drain();
    end

    if (errors == 0) begin
      $display("tb_ultimate_oscillator passed");
    end else begin
      $display("tb_ultimate_oscillator failed");
    end
    $finish;
  end

endmodule
